// ----- src/thop_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the tcp header and option parser
// no dependencies

package thop_pkg;

    // field identifiers carried on every output record
    typedef enum logic [3:0] {
        FID_SRCPORT   = 4'd0,
        FID_DSTPORT   = 4'd1,
        FID_SEQ       = 4'd2,
        FID_ACK       = 4'd3,
        FID_OFFSET    = 4'd4,
        FID_FLAGS     = 4'd5,
        FID_WINDOW    = 4'd6,
        FID_CHECKSUM  = 4'd7,
        FID_URGENT    = 4'd8,
        FID_MSS       = 4'd9,
        FID_WSCALE    = 4'd10,
        FID_SACKOK    = 4'd11,
        FID_SACKBLOCK = 4'd12,
        FID_TSTAMP    = 4'd13,
        FID_PAYLOAD   = 4'd14,
        FID_STATUS    = 4'd15
    } t_field_id;

    // segment status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_SHORT     = 2'd1,
        STS_BADOFFSET = 2'd2,
        STS_OVERRUN   = 2'd3
    } t_status;

    // option kinds
    localparam logic [7:0] OPT_END       = 8'd0;
    localparam logic [7:0] OPT_NOP       = 8'd1;
    localparam logic [7:0] OPT_MSS       = 8'd2;
    localparam logic [7:0] OPT_WSCALE    = 8'd3;
    localparam logic [7:0] OPT_SACKOK    = 8'd4;
    localparam logic [7:0] OPT_SACK      = 8'd5;
    localparam logic [7:0] OPT_TSTAMP    = 8'd8;

    localparam logic [5:0] HDR_FIXED_BYTES   = 6'd20;
    localparam logic [5:0] POS_MAX           = 6'd63;
    localparam logic [3:0] WSCALE_LIMIT_INIT = 4'd14;
    localparam int         REC_FIFO_DEPTH    = 4;

    typedef struct packed {
        t_field_id   id;
        logic [63:0] value;
        logic        last;
    } t_record;

    // records produced by one accepted beat, already packed to the front
    typedef struct packed {
        logic [1:0] cnt;
        t_record    rec_a;
        t_record    rec_b;
    } t_push;

endpackage

// ----- src/thop_parse.sv -----
`timescale 1ns / 1ps
// per-byte header, option and payload decode; window scale limit register
// depends on thop_pkg

module thop_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_seg_byte,
    input  logic            i_seg_end,
    input  logic            i_cfg_wr_en,
    input  logic [3:0]      i_cfg_wr_data,
    output thop_pkg::t_push o_push
);
    import thop_pkg::*;

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LENGTH,
        PH_BODY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [5:0]  r_hdr_len, n_hdr_len;
    logic [63:0] r_shift, n_shift;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_len, n_len;
    logic [5:0]  r_off, n_off;
    logic        r_opt_stop, n_opt_stop;
    logic        r_bad_off, n_bad_off;
    logic [3:0]  r_ws_limit;

    logic        rec_v;
    t_record     rec;
    t_record     sts;
    logic [63:0] shifted;
    logic [3:0]  doff;
    logic [6:0]  seg_size;
    logic [8:0]  opt_end_pos;
    t_status     status;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_hdr_len  = r_hdr_len;
        n_shift    = r_shift;
        n_kind     = r_kind;
        n_len      = r_len;
        n_off      = r_off;
        n_opt_stop = r_opt_stop;
        n_bad_off  = r_bad_off;
        rec_v      = 1'b0;
        rec        = '{id: FID_PAYLOAD, value: 64'd0, last: 1'b0};
        shifted    = {r_shift[55:0], i_seg_byte};
        doff       = i_seg_byte[7:4];
        opt_end_pos = {3'd0, r_pos} - 9'd1 + {1'b0, i_seg_byte};

        if (r_pos < HDR_FIXED_BYTES) begin
            // fixed header: big-endian accumulate, emit on field boundaries
            n_shift = shifted;
            unique case (r_pos)
                6'd1: begin
                    rec_v = 1'b1; rec.id = FID_SRCPORT;
                    rec.value = {48'd0, shifted[15:0]}; n_shift = '0;
                end
                6'd3: begin
                    rec_v = 1'b1; rec.id = FID_DSTPORT;
                    rec.value = {48'd0, shifted[15:0]}; n_shift = '0;
                end
                6'd7: begin
                    rec_v = 1'b1; rec.id = FID_SEQ;
                    rec.value = {32'd0, shifted[31:0]}; n_shift = '0;
                end
                6'd11: begin
                    rec_v = 1'b1; rec.id = FID_ACK;
                    rec.value = {32'd0, shifted[31:0]}; n_shift = '0;
                end
                6'd12: begin
                    rec_v = 1'b1; rec.id = FID_OFFSET;
                    rec.value = {60'd0, doff}; n_shift = '0;
                    if (doff < 4'd5) begin
                        n_bad_off = 1'b1;
                        n_hdr_len = HDR_FIXED_BYTES;
                    end else begin
                        n_hdr_len = {doff, 2'b00};
                    end
                end
                6'd13: begin
                    rec_v = 1'b1; rec.id = FID_FLAGS;
                    rec.value = {56'd0, i_seg_byte}; n_shift = '0;
                end
                6'd15: begin
                    rec_v = 1'b1; rec.id = FID_WINDOW;
                    rec.value = {48'd0, shifted[15:0]}; n_shift = '0;
                end
                6'd17: begin
                    rec_v = 1'b1; rec.id = FID_CHECKSUM;
                    rec.value = {48'd0, shifted[15:0]}; n_shift = '0;
                end
                6'd19: begin
                    rec_v = 1'b1; rec.id = FID_URGENT;
                    rec.value = {48'd0, shifted[15:0]}; n_shift = '0;
                end
                default: ;
            endcase
        end else if (r_pos < r_hdr_len) begin
            if (!r_opt_stop) begin
                unique case (r_phase)
                    PH_KIND: begin
                        if (i_seg_byte == OPT_END) begin
                            n_opt_stop = 1'b1;
                        end else if (i_seg_byte == OPT_NOP) begin
                            n_opt_stop = r_opt_stop;
                        end else if (({1'b0, r_pos} + 7'd1) >= {1'b0, r_hdr_len}) begin
                            // kind in the last header byte: truncated
                            n_opt_stop = 1'b1;
                        end else begin
                            n_kind  = i_seg_byte;
                            n_phase = PH_LENGTH;
                            n_off   = 6'd1;
                        end
                    end
                    PH_LENGTH: begin
                        if (i_seg_byte < 8'd2 || opt_end_pos > {3'd0, r_hdr_len}) begin
                            n_opt_stop = 1'b1;
                        end else begin
                            n_len = i_seg_byte;
                            if (r_kind == OPT_SACKOK && i_seg_byte == 8'd2) begin
                                rec_v = 1'b1; rec.id = FID_SACKOK; rec.value = 64'd1;
                            end
                            if (i_seg_byte == 8'd2) begin
                                n_phase = PH_KIND;
                            end else begin
                                n_phase = PH_BODY;
                                n_off   = 6'd2;
                                n_shift = '0;
                            end
                        end
                    end
                    PH_BODY: begin
                        n_shift = shifted;
                        if (r_kind == OPT_MSS && r_len == 8'd4 && r_off == 6'd3) begin
                            rec_v = 1'b1; rec.id = FID_MSS;
                            rec.value = {48'd0, shifted[15:0]};
                        end else if (r_kind == OPT_WSCALE && r_len == 8'd3 &&
                                     r_off == 6'd2) begin
                            rec_v = 1'b1; rec.id = FID_WSCALE;
                            rec.value = (i_seg_byte > {4'd0, r_ws_limit}) ?
                                        {60'd0, r_ws_limit} : {56'd0, i_seg_byte};
                        end else if (r_kind == OPT_TSTAMP && r_len == 8'd10 &&
                                     r_off == 6'd9) begin
                            rec_v = 1'b1; rec.id = FID_TSTAMP; rec.value = shifted;
                        end else if (r_kind == OPT_SACK && r_len >= 8'd10 &&
                                     r_len[2:0] == 3'd2 && r_off[2:0] == 3'd1) begin
                            // last byte of an 8-byte sack block
                            rec_v = 1'b1; rec.id = FID_SACKBLOCK; rec.value = shifted;
                            n_shift = '0;
                        end
                        if (({2'd0, r_off} + 8'd1) >= r_len) begin
                            n_phase = PH_KIND;
                        end else begin
                            n_off = r_off + 6'd1;
                        end
                    end
                    default: n_phase = PH_KIND;
                endcase
            end
        end else begin
            rec_v = 1'b1; rec.id = FID_PAYLOAD; rec.value = {56'd0, i_seg_byte};
        end

        // closing status, judged on the state as this beat leaves it
        seg_size = {1'b0, r_pos} + 7'd1;
        if (seg_size < {1'b0, HDR_FIXED_BYTES}) begin
            status = STS_SHORT;
        end else if (n_bad_off) begin
            status = STS_BADOFFSET;
        end else if ({1'b0, n_hdr_len} > seg_size) begin
            status = STS_OVERRUN;
        end else begin
            status = STS_OK;
        end
        sts = '{id: FID_STATUS, value: {62'd0, status}, last: 1'b1};

        if (i_seg_end) begin
            n_phase    = PH_KIND;
            n_pos      = '0;
            n_hdr_len  = '0;
            n_shift    = '0;
            n_kind     = '0;
            n_len      = '0;
            n_off      = '0;
            n_opt_stop = 1'b0;
            n_bad_off  = 1'b0;
        end else if (r_pos < POS_MAX) begin
            n_pos = r_pos + 6'd1;
        end

        // pack present records to the front
        o_push.rec_a = rec_v ? rec : sts;
        o_push.rec_b = sts;
        if (!i_accept) begin
            o_push.cnt = 2'd0;
        end else if (rec_v && i_seg_end) begin
            o_push.cnt = 2'd2;
        end else if (rec_v || i_seg_end) begin
            o_push.cnt = 2'd1;
        end else begin
            o_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_KIND;
            r_pos      <= '0;
            r_hdr_len  <= '0;
            r_shift    <= '0;
            r_kind     <= '0;
            r_len      <= '0;
            r_off      <= '0;
            r_opt_stop <= 1'b0;
            r_bad_off  <= 1'b0;
            r_ws_limit <= WSCALE_LIMIT_INIT;
        end else begin
            if (i_cfg_wr_en) begin
                r_ws_limit <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_phase    <= n_phase;
                r_pos      <= n_pos;
                r_hdr_len  <= n_hdr_len;
                r_shift    <= n_shift;
                r_kind     <= n_kind;
                r_len      <= n_len;
                r_off      <= n_off;
                r_opt_stop <= n_opt_stop;
                r_bad_off  <= n_bad_off;
            end
        end
    end

    a_hdr_len_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos > 6'd12) |-> (r_hdr_len >= HDR_FIXED_BYTES))
        else $error("header length not set past the offset byte");

    a_opt_phase_in_opts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_KIND) |-> (r_pos > HDR_FIXED_BYTES))
        else $error("option parse active outside the option area");

    a_status_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (o_push.rec_b.last && !o_push.rec_a.last))
        else $error("status record not last of a double push");

endmodule

// ----- src/thop_fifo.sv -----
`timescale 1ns / 1ps
// small record queue, up to two pushes and one pop per cycle
// depends on thop_pkg

module thop_fifo #(
    parameter int P_DEPTH = thop_pkg::REC_FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  thop_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_valid,
    output thop_pkg::t_record o_rec,
    output logic              o_space2
);
    import thop_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);

    t_record          r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wptr_inc, wptr_inc2, rptr_inc;
    logic             pop;

    assign wptr_inc  = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
    assign wptr_inc2 = (wptr_inc == PTR_LAST) ? '0 : wptr_inc + 1'b1;
    assign rptr_inc  = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
    assign pop       = i_pop && (r_count != '0);

    assign o_valid  = (r_count != '0);
    assign o_rec    = r_mem[r_rptr];
    assign o_space2 = (r_count <= CNT_W'(P_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_push.rec_a;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wptr_inc] <= i_push.rec_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.cnt == 2'd1) begin
                r_wptr <= wptr_inc;
            end else if (i_push.cnt == 2'd2) begin
                r_wptr <= wptr_inc2;
            end
            if (pop) begin
                r_rptr <= rptr_inc;
            end
            r_count <= r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_count <= CNT_W'(P_DEPTH - 2)))
        else $error("record queue pushed without room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("record queue count lost a pop");

endmodule

// ----- src/tcp_header_option_parser.sv -----
`timescale 1ns / 1ps
// tcp header and option parser: one segment byte per beat in, records out
// depends on thop_pkg, thop_parse, thop_fifo
// output: a byte's records are registered in the record queue as it is taken, behind any older records
// throughput: one byte per cycle; a final byte that also closes a field yields two
//   records, and input ready drops while the record queue has fewer than two free slots
// reset: synchronous active low; clears parser state and the record queue, window
//   scale limit returns to 14

module tcp_header_option_parser #(
    parameter int P_FIFO_DEPTH = thop_pkg::REC_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // segment byte beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_seg_byte,
    input  logic        i_seg_end,
    // record beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_field_id,
    output logic [63:0] o_field_value,
    output logic        o_record_last,
    // window scale limit register
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data
);
    import thop_pkg::*;

    t_push   w_push;
    t_record w_rec;
    logic    w_space2;
    logic    w_accept;

    // a beat is taken only when the queue can hold both of its records
    assign o_in_ready = w_space2;
    assign w_accept   = i_in_valid && w_space2;

    // all decode for a byte happens in the accept cycle; the queue is the result register
    thop_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_seg_byte    (i_seg_byte),
        .i_seg_end     (i_seg_end),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (w_push)
    );

    // record queue parts the input and output handshakes
    thop_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (i_out_ready),
        .o_valid  (o_out_valid),
        .o_rec    (w_rec),
        .o_space2 (w_space2)
    );

    // record fields out
    assign o_field_id    = w_rec.id;
    assign o_field_value = w_rec.value;
    assign o_record_last = w_rec.last;

endmodule
